// ===== hw/rtl/ecal_pkg.sv =====
// shared types, widths and month table for the epoch-to-calendar converter
package ecal_pkg;

  localparam int unsigned SECS_W   = 31;
  localparam int unsigned DAYS_W   = 15;
  localparam int unsigned YEAR_W   = 11;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned MP_W     = 4;
  localparam int unsigned DOY_W    = 9;

  // day count split off the raw seconds, first stage output
  typedef struct packed {
    logic              vld;
    logic [DAYS_W-1:0] days;
    logic [SECS_W-1:0] secs;
  } split_t;

  typedef struct packed {
    logic               vld;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic                vld;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } tod_t;

  // first day of each march-based month within the year, (153*mp+2)/5
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] res;
    case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/epoch_seconds_to_calendar_top.sv =====
// top level: unix seconds to gregorian date and time of day
//
//   channel  | ports                               | handshake
//   ---------+-------------------------------------+----------------------------
//   request  | in_epoch_seconds                    | start high, busy low
//   result   | out_year/month/day/hour/minute/...  | out_valid strobe, one cycle
//
// a request is taken in every cycle; busy stays low
// each result passes one day-split stage, five stages in the parallel date and
// time-of-day pipelines, and one output register
// reset clears the valid bits only, so no result comes out of a flushed pipe
// the receiver cannot stall, so nothing is ever held back
module epoch_seconds_to_calendar_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ecal_pkg::SECS_W-1:0]   in_epoch_seconds,
  output logic                          out_valid,
  output logic [ecal_pkg::YEAR_W-1:0]   out_year,
  output logic [ecal_pkg::MONTH_W-1:0]  out_month,
  output logic [ecal_pkg::DAY_W-1:0]    out_day,
  output logic [ecal_pkg::HOUR_W-1:0]   out_hour,
  output logic [ecal_pkg::MINUTE_W-1:0] out_minute,
  output logic [ecal_pkg::SECOND_W-1:0] out_second
);

  localparam int unsigned LATENCY = 7;

  ecal_pkg::split_t split_s;
  ecal_pkg::date_t  date_s;
  ecal_pkg::tod_t   tod_s;
  logic             req_acc;

  assign busy    = 1'b0;
  assign req_acc = start && !busy;

  ecal_split u_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (req_acc),
    .in_secs (in_epoch_seconds),
    .split_o (split_s)
  );

  ecal_date u_date (
    .clk     (clk),
    .rst_n   (rst_n),
    .split_i (split_s),
    .date_o  (date_s)
  );

  ecal_tod u_tod (
    .clk     (clk),
    .rst_n   (rst_n),
    .split_i (split_s),
    .tod_o   (tod_s)
  );

  logic                          out_vld_r;
  logic [ecal_pkg::YEAR_W-1:0]   year_r;
  logic [ecal_pkg::MONTH_W-1:0]  month_r;
  logic [ecal_pkg::DAY_W-1:0]    day_r;
  logic [ecal_pkg::HOUR_W-1:0]   hour_r;
  logic [ecal_pkg::MINUTE_W-1:0] minute_r;
  logic [ecal_pkg::SECOND_W-1:0] second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= date_s.vld;
    end
  end

  always_ff @(posedge clk) begin
    year_r   <= date_s.year;
    month_r  <= date_s.month;
    day_r    <= date_s.day;
    hour_r   <= tod_s.hour;
    minute_r <= tod_s.minute;
    second_r <= tod_s.second;
  end

  assign out_valid  = out_vld_r;
  assign out_year   = year_r;
  assign out_month  = month_r;
  assign out_day    = day_r;
  assign out_hour   = hour_r;
  assign out_minute = minute_r;
  assign out_second = second_r;

  // both halves must stay in step
  a_halves_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    date_s.vld == tod_s.vld)
    else $error("date and time-of-day pipelines out of step");

  a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    req_acc |-> ##LATENCY out_valid)
    else $error("request produced no result");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(req_acc, LATENCY))
    else $error("result without a request");

  a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1 &&
                   out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59 &&
                   out_year >= 11'd1970 && out_year <= 11'd2038))
    else $error("calendar field out of range");

endmodule

// ===== hw/rtl/ecal_split.sv =====
// first stage: whole days since the epoch by reciprocal multiply
module ecal_split (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [ecal_pkg::SECS_W-1:0] in_secs,
  output ecal_pkg::split_t            split_o
);

  // s / 86400 == (s >> 7) / 675
  localparam int unsigned HI_W   = ecal_pkg::SECS_W - 7;
  localparam int unsigned DAY_K  = 34;
  localparam int unsigned PROD_W = 49;
  localparam logic [24:0] DAY_M  = 25'(((64'd1 << DAY_K) + 64'd674) / 64'd675);

  logic [HI_W-1:0]             secs_hi;
  logic [PROD_W-1:0]           day_prod;
  logic [ecal_pkg::DAYS_W-1:0] days_nxt;
  logic                        vld_r;
  logic [ecal_pkg::DAYS_W-1:0] days_r;
  logic [ecal_pkg::SECS_W-1:0] secs_r;

  assign secs_hi  = in_secs[ecal_pkg::SECS_W-1:7];
  assign day_prod = PROD_W'(secs_hi) * PROD_W'(DAY_M);
  assign days_nxt = day_prod[DAY_K +: ecal_pkg::DAYS_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    days_r <= days_nxt;
    secs_r <= in_secs;
  end

  assign split_o.vld  = vld_r;
  assign split_o.days = days_r;
  assign split_o.secs = secs_r;

endmodule

// ===== hw/rtl/ecal_date.sv =====
// date pipeline: day count to year, month and day over five stages
module ecal_date (
  input  logic             clk,
  input  logic             rst_n,
  input  ecal_pkg::split_t split_i,
  output ecal_pkg::date_t  date_o
);

  localparam int unsigned DOE_W   = 18;
  localparam int unsigned YOE_W   = 9;
  localparam int unsigned DOY_W   = ecal_pkg::DOY_W;
  localparam int unsigned MP_W    = ecal_pkg::MP_W;
  // days from 1970-01-01 to 2000-03-01, start of the later era
  localparam logic [DOE_W-1:0] ERA_SPLIT = 18'd11017;
  // day of era of 1970-01-01 in the era from 1600-03-01
  localparam logic [DOE_W-1:0] ERA_OFS   = 18'd135080;
  localparam int unsigned K1460 = 29;
  localparam logic [18:0] M1460 = 19'(((64'd1 << K1460) + 64'd1459) / 64'd1460);
  localparam int unsigned K365  = 27;
  localparam logic [18:0] M365  = 19'(((64'd1 << K365) + 64'd364) / 64'd365);
  localparam int unsigned K153  = 19;
  localparam logic [11:0] M153  = 12'(((64'd1 << K153) + 64'd152) / 64'd153);

  // stage 1: day of era
  logic             d1_vld_r;
  logic [DOE_W-1:0] d1_doe_r;
  logic             d1_era_r;
  logic [DOE_W-1:0] days_ext;
  logic             era_nxt;
  logic [DOE_W-1:0] doe_nxt;

  assign days_ext = DOE_W'(split_i.days);
  assign era_nxt  = (days_ext >= ERA_SPLIT);
  assign doe_nxt  = era_nxt ? (days_ext - ERA_SPLIT) : (days_ext + ERA_OFS);

  // stage 2: leap-corrected day count
  logic             d2_vld_r;
  logic [DOE_W-1:0] d2_t_r;
  logic [DOE_W-1:0] d2_doe_r;
  logic             d2_era_r;
  logic [36:0]      q1460_prod;
  logic [DOE_W-1:0] q1460;
  logic [DOE_W-1:0] c36524;
  logic [DOE_W-1:0] c146096;
  logic [DOE_W-1:0] t_nxt;

  assign q1460_prod = 37'(d1_doe_r) * 37'(M1460);
  assign q1460      = DOE_W'(q1460_prod[36:K1460]);
  assign c36524     = DOE_W'(d1_doe_r >= 18'd36524) + DOE_W'(d1_doe_r >= 18'd73048)
                    + DOE_W'(d1_doe_r >= 18'd109572) + DOE_W'(d1_doe_r >= 18'd146096);
  assign c146096    = DOE_W'(d1_doe_r >= 18'd146096);
  assign t_nxt      = d1_doe_r - q1460 + c36524 - c146096;

  // stage 3: year of era
  logic             d3_vld_r;
  logic [YOE_W-1:0] d3_yoe_r;
  logic [DOE_W-1:0] d3_doe_r;
  logic             d3_era_r;
  logic [36:0]      yoe_prod;
  logic [YOE_W-1:0] yoe_nxt;

  assign yoe_prod = 37'(d2_t_r) * 37'(M365);
  assign yoe_nxt  = yoe_prod[K365 +: YOE_W];

  // stage 4: day of march-based year
  logic             d4_vld_r;
  logic [DOY_W-1:0] d4_doy_r;
  logic [YOE_W-1:0] d4_yoe_r;
  logic             d4_era_r;
  logic [DOE_W-1:0] c100;
  logic [DOE_W-1:0] year_days;
  logic [DOE_W-1:0] doy_full;

  assign c100      = DOE_W'(d3_yoe_r >= 9'd100) + DOE_W'(d3_yoe_r >= 9'd200)
                   + DOE_W'(d3_yoe_r >= 9'd300);
  assign year_days = DOE_W'(DOE_W'(d3_yoe_r) * 18'd365) + DOE_W'(d3_yoe_r >> 2) - c100;
  assign doy_full  = d3_doe_r - year_days;

  // stage 5: march-based month by the 153/5 rule
  logic             d5_vld_r;
  logic [MP_W-1:0]  d5_mp_r;
  logic [DOY_W-1:0] d5_doy_r;
  logic [YOE_W-1:0] d5_yoe_r;
  logic             d5_era_r;
  logic [10:0]      mp_num;
  logic [22:0]      mp_prod;
  logic [MP_W-1:0]  mp_nxt;

  assign mp_num  = 11'(11'(d4_doy_r) * 11'd5) + 11'd2;
  assign mp_prod = 23'(mp_num) * 23'(M153);
  assign mp_nxt  = mp_prod[K153 +: MP_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r <= 1'b0;
      d2_vld_r <= 1'b0;
      d3_vld_r <= 1'b0;
      d4_vld_r <= 1'b0;
      d5_vld_r <= 1'b0;
    end else begin
      d1_vld_r <= split_i.vld;
      d2_vld_r <= d1_vld_r;
      d3_vld_r <= d2_vld_r;
      d4_vld_r <= d3_vld_r;
      d5_vld_r <= d4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_doe_r <= doe_nxt;
    d1_era_r <= era_nxt;
    d2_t_r   <= t_nxt;
    d2_doe_r <= d1_doe_r;
    d2_era_r <= d1_era_r;
    d3_yoe_r <= yoe_nxt;
    d3_doe_r <= d2_doe_r;
    d3_era_r <= d2_era_r;
    d4_doy_r <= doy_full[DOY_W-1:0];
    d4_yoe_r <= d3_yoe_r;
    d4_era_r <= d3_era_r;
    d5_mp_r  <= mp_nxt;
    d5_doy_r <= d4_doy_r;
    d5_yoe_r <= d4_yoe_r;
    d5_era_r <= d4_era_r;
  end

  // january and february fall in the next civil year
  logic [ecal_pkg::MONTH_W-1:0] month_c;
  logic [ecal_pkg::YEAR_W-1:0]  era_base;
  logic [DOY_W-1:0]             day_c;

  assign month_c  = (d5_mp_r < 4'd10) ? (d5_mp_r + 4'd3) : (d5_mp_r - 4'd9);
  assign era_base = d5_era_r ? 11'd2000 : 11'd1600;
  assign day_c    = d5_doy_r - ecal_pkg::month_start(d5_mp_r) + 9'd1;

  assign date_o.vld   = d5_vld_r;
  assign date_o.month = month_c;
  assign date_o.day   = day_c[ecal_pkg::DAY_W-1:0];
  assign date_o.year  = era_base + ecal_pkg::YEAR_W'(d5_yoe_r)
                      + ecal_pkg::YEAR_W'(month_c <= 4'd2);

endmodule

// ===== hw/rtl/ecal_tod.sv =====
// time-of-day pipeline: seconds of day to hour, minute and second over five stages
module ecal_tod (
  input  logic             clk,
  input  logic             rst_n,
  input  ecal_pkg::split_t split_i,
  output ecal_pkg::tod_t   tod_o
);

  localparam int unsigned SOD_W  = 17;
  localparam int unsigned REMH_W = 12;
  localparam int unsigned K3600  = 29;
  localparam logic [17:0] M3600  = 18'(((64'd1 << K3600) + 64'd3599) / 64'd3600);
  localparam int unsigned K60    = 18;
  localparam logic [12:0] M60    = 13'(((64'd1 << K60) + 64'd59) / 64'd60);

  // stage 1: seconds within the day
  logic                        t1_vld_r;
  logic [SOD_W-1:0]            t1_sod_r;
  logic [ecal_pkg::SECS_W-1:0] day_secs;
  logic [ecal_pkg::SECS_W-1:0] sod_full;

  assign day_secs = ecal_pkg::SECS_W'(ecal_pkg::SECS_W'(split_i.days) * 31'd86400);
  assign sod_full = split_i.secs - day_secs;

  // stage 2: hour
  logic                        t2_vld_r;
  logic [ecal_pkg::HOUR_W-1:0] t2_hour_r;
  logic [SOD_W-1:0]            t2_sod_r;
  logic [34:0]                 hour_prod;

  assign hour_prod = 35'(t1_sod_r) * 35'(M3600);

  // stage 3: seconds within the hour
  logic                        t3_vld_r;
  logic [ecal_pkg::HOUR_W-1:0] t3_hour_r;
  logic [REMH_W-1:0]           t3_remh_r;
  logic [SOD_W-1:0]            hour_secs;
  logic [SOD_W-1:0]            remh_full;

  assign hour_secs = SOD_W'(SOD_W'(t2_hour_r) * 17'd3600);
  assign remh_full = t2_sod_r - hour_secs;

  // stage 4: minute
  logic                          t4_vld_r;
  logic [ecal_pkg::HOUR_W-1:0]   t4_hour_r;
  logic [ecal_pkg::MINUTE_W-1:0] t4_min_r;
  logic [REMH_W-1:0]             t4_remh_r;
  logic [24:0]                   min_prod;

  assign min_prod = 25'(t3_remh_r) * 25'(M60);

  // stage 5: second
  logic                          t5_vld_r;
  logic [ecal_pkg::HOUR_W-1:0]   t5_hour_r;
  logic [ecal_pkg::MINUTE_W-1:0] t5_min_r;
  logic [ecal_pkg::SECOND_W-1:0] t5_sec_r;
  logic [REMH_W-1:0]             min_secs;
  logic [REMH_W-1:0]             sec_full;

  assign min_secs = REMH_W'(REMH_W'(t4_min_r) * 12'd60);
  assign sec_full = t4_remh_r - min_secs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
      t3_vld_r <= 1'b0;
      t4_vld_r <= 1'b0;
      t5_vld_r <= 1'b0;
    end else begin
      t1_vld_r <= split_i.vld;
      t2_vld_r <= t1_vld_r;
      t3_vld_r <= t2_vld_r;
      t4_vld_r <= t3_vld_r;
      t5_vld_r <= t4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_sod_r  <= sod_full[SOD_W-1:0];
    t2_hour_r <= hour_prod[K3600 +: ecal_pkg::HOUR_W];
    t2_sod_r  <= t1_sod_r;
    t3_hour_r <= t2_hour_r;
    t3_remh_r <= remh_full[REMH_W-1:0];
    t4_hour_r <= t3_hour_r;
    t4_min_r  <= min_prod[K60 +: ecal_pkg::MINUTE_W];
    t4_remh_r <= t3_remh_r;
    t5_hour_r <= t4_hour_r;
    t5_min_r  <= t4_min_r;
    t5_sec_r  <= sec_full[ecal_pkg::SECOND_W-1:0];
  end

  assign tod_o.vld    = t5_vld_r;
  assign tod_o.hour   = t5_hour_r;
  assign tod_o.minute = t5_min_r;
  assign tod_o.second = t5_sec_r;

endmodule
